### src/ert_pkg.sv
// Shared types and constants for the endpoint registry table.
package ert_pkg;

    localparam int SLOTS_DEF = 64;

    localparam int MODE_W   = 2;
    localparam int OWNER_W  = 16;
    localparam int NUMBER_W = 32;
    localparam int REF_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;

    localparam logic [MODE_W-1:0] MODE_LOOKUP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [OWNER_W-1:0]  owner;
        logic [NUMBER_W-1:0] number;
        logic [REF_W-1:0]    ref_val;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REF_W-1:0]    ref_val;
        logic [SLOT_W-1:0]   slot;
    } result_t;

endpackage

### src/ert_mem.sv
// Slot store: one write port, one read port, registered read data.
module ert_mem #(
    parameter int DEPTH = ert_pkg::SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output ert_pkg::entry_t     rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  ert_pkg::entry_t     wr_data
);
    import ert_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/ert_ctrl.sv
// Scan sequencer: clears the store, then walks the slots one per cycle for each lookup, register or release request.
module ert_ctrl #(
    parameter int SLOTS = ert_pkg::SLOTS_DEF,
    parameter int IDX_W = $clog2(SLOTS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [ert_pkg::MODE_W-1:0]    mode,
    input  logic [ert_pkg::OWNER_W-1:0]   owner_id,
    input  logic [ert_pkg::NUMBER_W-1:0]  endpoint_number,
    input  logic [ert_pkg::REF_W-1:0]     endpoint_ref_in,
    output logic                          res_valid,
    input  logic                          res_take,
    output ert_pkg::result_t              res,
    output logic                          rd_en,
    output logic [IDX_W-1:0]              rd_addr,
    input  ert_pkg::entry_t               rd_data,
    output logic                          wr_en,
    output logic [IDX_W-1:0]              wr_addr,
    output ert_pkg::entry_t               wr_data
);
    import ert_pkg::*;

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]    hwm_reg, hwm_next;
    logic [MODE_W-1:0]   op_mode_reg, op_mode_next;
    logic [OWNER_W-1:0]  op_owner_reg, op_owner_next;
    logic [NUMBER_W-1:0] op_number_reg, op_number_next;
    logic [REF_W-1:0]    op_ref_reg, op_ref_next;
    result_t             res_reg, res_next;

    logic                last_chk;
    logic                owner_hit;
    logic                number_hit;
    logic [EXT_W-1:0]    chk_idx_ext;
    logic [SLOT_W-1:0]   chk_slot;
    logic [CNT_W-1:0]    chk_plus1;

    assign req_ready   = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res         = res_reg;

    assign last_chk    = (chk_idx_reg == IDX_W'(SLOTS - 1));
    assign owner_hit   = rd_data.valid && (rd_data.owner == op_owner_reg);
    assign number_hit  = (rd_data.number == op_number_reg);
    assign chk_idx_ext = EXT_W'(chk_idx_reg);
    assign chk_slot    = chk_idx_ext[SLOT_W-1:0];
    assign chk_plus1   = CNT_W'(chk_idx_reg) + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        hwm_next       = hwm_reg;
        op_mode_next   = op_mode_reg;
        op_owner_next  = op_owner_reg;
        op_number_next = op_number_reg;
        op_ref_next    = op_ref_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = chk_idx_reg;
        wr_data        = rd_data;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[IDX_W-1:0];
                wr_data  = '0;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SLOTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_mode_next   = mode;
                    op_owner_next  = owner_id;
                    op_number_next = endpoint_number;
                    op_ref_next    = endpoint_ref_in;
                    cnt_next       = '0;
                    chk_vld_next   = 1'b0;
                    if (mode inside {MODE_LOOKUP, MODE_REGISTER, MODE_RELEASE})
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_next   = '{status: ST_OK, ref_val: '0, slot: '0};
                        state_next = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                // issue the next read while the previous slot is checked
                if (cnt_reg != CNT_W'(SLOTS))
                begin
                    rd_en        = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = cnt_reg[IDX_W-1:0];
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end

                if (chk_vld_reg)
                begin
                    case (op_mode_reg)
                        MODE_LOOKUP:
                        begin
                            if (owner_hit && number_hit)
                            begin
                                res_next = '{status: ST_OK, ref_val: rd_data.ref_val,
                                             slot: chk_slot};
                                state_next = S_DONE;
                            end
                            else if (last_chk)
                            begin
                                res_next = '{status: ST_NOT_FOUND, ref_val: '0, slot: '0};
                                state_next = S_DONE;
                            end
                        end

                        MODE_REGISTER:
                        begin
                            if (!rd_data.valid)
                            begin
                                wr_en   = 1'b1;
                                wr_data = '{valid: 1'b1, owner: op_owner_reg,
                                            number: op_number_reg, ref_val: op_ref_reg};
                                if (chk_plus1 > hwm_reg)
                                begin
                                    hwm_next = chk_plus1;
                                end
                                res_next = '{status: ST_OK, ref_val: '0, slot: chk_slot};
                                state_next = S_DONE;
                            end
                            else if (last_chk)
                            begin
                                res_next = '{status: ST_FULL, ref_val: '0, slot: '0};
                                state_next = S_DONE;
                            end
                        end

                        default:
                        begin
                            // release: drop the valid mark, keep the rest
                            if (owner_hit)
                            begin
                                wr_en         = 1'b1;
                                wr_data       = rd_data;
                                wr_data.valid = 1'b0;
                            end
                            if (last_chk)
                            begin
                                res_next = '{status: ST_OK, ref_val: '0, slot: '0};
                                state_next = S_DONE;
                            end
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
            hwm_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            chk_vld_reg <= chk_vld_next;
            hwm_reg     <= hwm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg   <= chk_idx_next;
        op_mode_reg   <= op_mode_next;
        op_owner_reg  <= op_owner_next;
        op_number_reg <= op_number_next;
        op_ref_reg    <= op_ref_next;
        res_reg       <= res_next;
    end

endmodule

### src/endpoint_registry_table.sv
// Endpoint registry table: slot store, scan sequencer and result register.
// After reset the store is cleared one slot per cycle; no request is taken then.
// A request walks the slots through the single read port of the store, one slot per cycle.
// Lookup and register end at the first hit; release always walks every slot.
// One request is in flight at a time.
// The result register holds one finished result so the next request can be taken meanwhile.
module endpoint_registry_table #(
    parameter int SLOTS = ert_pkg::SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [ert_pkg::MODE_W-1:0]    mode,
    input  logic [ert_pkg::OWNER_W-1:0]   owner_id,
    input  logic [ert_pkg::NUMBER_W-1:0]  endpoint_number,
    input  logic [ert_pkg::REF_W-1:0]     endpoint_ref_in,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [ert_pkg::STATUS_W-1:0]  status,
    output logic [ert_pkg::REF_W-1:0]     endpoint_ref_out,
    output logic [ert_pkg::SLOT_W-1:0]    slot
);
    import ert_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic              res_valid;
    logic              res_take;
    result_t           res;
    logic              rsp_valid_reg;
    result_t           rsp_res_reg;

    ert_mem #(
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ert_ctrl #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .mode            (mode),
        .owner_id        (owner_id),
        .endpoint_number (endpoint_number),
        .endpoint_ref_in (endpoint_ref_in),
        .res_valid       (res_valid),
        .res_take        (res_take),
        .res             (res),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data)
    );

    // load when the register is empty or its transfer completes this cycle
    assign res_take = res_valid && (!rsp_valid_reg || rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_res_reg <= res;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign status           = rsp_res_reg.status;
    assign endpoint_ref_out = rsp_res_reg.ref_val;
    assign slot             = rsp_res_reg.slot;

endmodule

### tb/tb.sv
// Testbench for the endpoint registry table with a slot-store predictor.
`timescale 1ns / 1ps

module tb;
    import ert_pkg::*;

    localparam int NSLOTS       = SLOTS_DEF;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_CYCLES = 4 * NSLOTS;
    localparam int MAX_REPORTS  = 10;
    localparam int OWNER_POOL   = 6;
    localparam int RANDOM_ITEMS = 160;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                clk             = 1'b0;
    logic                rst_n           = 1'b0;
    logic                req_valid       = 1'b0;
    logic                req_ready;
    logic [MODE_W-1:0]   mode            = MODE_LOOKUP;
    logic [OWNER_W-1:0]  owner_id        = '0;
    logic [NUMBER_W-1:0] endpoint_number = '0;
    logic [REF_W-1:0]    endpoint_ref_in = '0;
    logic                rsp_valid;
    logic                rsp_ready       = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [REF_W-1:0]    endpoint_ref_out;
    logic [SLOT_W-1:0]   slot;

    // Predicted registry contents
    logic                tbl_live  [NSLOTS];
    logic [OWNER_W-1:0]  tbl_owner [NSLOTS];
    logic [NUMBER_W-1:0] tbl_num   [NSLOTS];
    logic [REF_W-1:0]    tbl_ref   [NSLOTS];
    int                  tbl_hwm;

    result_t             pending_results[$];
    logic [OWNER_W-1:0]  owner_pool [OWNER_POOL];

    int mismatches     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    endpoint_registry_table #(
        .SLOTS(NSLOTS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .mode             (mode),
        .owner_id         (owner_id),
        .endpoint_number  (endpoint_number),
        .endpoint_ref_in  (endpoint_ref_in),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .status           (status),
        .endpoint_ref_out (endpoint_ref_out),
        .slot             (slot)
    );

    always #1 clk = ~clk;

    function automatic result_t predict_registry_op(input logic [MODE_W-1:0] m,
                                                    input logic [OWNER_W-1:0] own,
                                                    input logic [NUMBER_W-1:0] num,
                                                    input logic [REF_W-1:0] rin);
        result_t r;
        bit      hit;
        r   = '0;
        hit = 1'b0;
        if (m == MODE_LOOKUP)
        begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < NSLOTS && !hit; i++)
            begin
                if (tbl_live[i] && tbl_owner[i] == own && tbl_num[i] == num)
                begin
                    hit       = 1'b1;
                    r.status  = ST_OK;
                    r.ref_val = tbl_ref[i];
                    r.slot    = SLOT_W'(i);
                end
            end
        end
        else if (m == MODE_REGISTER)
        begin
            r.status = ST_FULL;
            for (int i = 0; i < NSLOTS && !hit; i++)
            begin
                if (!tbl_live[i])
                begin
                    hit          = 1'b1;
                    tbl_live[i]  = 1'b1;
                    tbl_owner[i] = own;
                    tbl_num[i]   = num;
                    tbl_ref[i]   = rin;
                    if (i + 1 > tbl_hwm)
                        tbl_hwm = i + 1;
                    r.status     = ST_OK;
                    r.slot       = SLOT_W'(i);
                end
            end
        end
        else if (m == MODE_RELEASE)
        begin
            for (int i = 0; i < NSLOTS; i++)
            begin
                if (tbl_live[i] && tbl_owner[i] == own)
                    tbl_live[i] = 1'b0;
            end
        end
        return r;
    endfunction

    // First live slot at or after start, wrapping; -1 when the table is empty.
    function automatic int find_live_slot(input int start);
        int idx;
        for (int k = 0; k < NSLOTS; k++)
        begin
            idx = (start + k) % NSLOTS;
            if (tbl_live[idx])
                return idx;
        end
        return -1;
    endfunction

    task automatic send_op(input logic [MODE_W-1:0] m, input logic [OWNER_W-1:0] own,
                           input logic [NUMBER_W-1:0] num, input logic [REF_W-1:0] rin);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid       = 1'b1;
        mode            = m;
        owner_id        = own;
        endpoint_number = num;
        endpoint_ref_in = rin;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_results.push_back(predict_registry_op(m, own, num, rin));
    endtask

    task automatic wait_drain();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic refresh_owner_pool();
        for (int j = 0; j < OWNER_POOL; j++)
            owner_pool[j] = OWNER_W'($urandom);
        owner_pool[0] = $urandom_range(1) ? '1 : '0;
    endtask

    task automatic release_all_live();
        int idx;
        idx = find_live_slot(0);
        while (idx >= 0)
        begin
            send_op(MODE_RELEASE, tbl_owner[idx], NUMBER_W'($urandom), REF_W'($urandom));
            idx = find_live_slot(0);
        end
    endtask

    task automatic test_directed_cases();
        send_op(MODE_LOOKUP,   16'h0000, 32'h0000_0000, 16'h0000);  // miss on empty table
        send_op(MODE_REGISTER, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(MODE_REGISTER, 16'h0000, 32'h0000_0000, 16'h0000);  // zero reference stays valid
        send_op(MODE_LOOKUP,   16'h0000, 32'h0000_0000, 16'hFFFF);
        send_op(MODE_LOOKUP,   16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
        send_op(MODE_LOOKUP,   16'hFFFF, 32'h0000_0000, 16'h0000);  // owner matches, number not
        send_op(MODE_REGISTER, 16'h0000, 32'h0000_0000, 16'hA5C3);  // duplicate entry
        send_op(MODE_LOOKUP,   16'h0000, 32'h0000_0000, 16'h0000);  // lowest duplicate wins
        send_op(MODE_UNUSED,   16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(MODE_RELEASE,  16'h1234, 32'h0000_0000, 16'h0000);  // no owner match
        send_op(MODE_RELEASE,  16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(MODE_LOOKUP,   16'h0000, 32'h0000_0000, 16'h0000);
        send_op(MODE_REGISTER, 16'h5A5A, 32'h8000_0001, 16'h0001);  // reuses the lowest freed slot
        send_op(MODE_LOOKUP,   16'h5A5A, 32'h8000_0001, 16'h0000);
        send_op(MODE_RELEASE,  16'hFFFF, 32'h0000_0000, 16'h0000);
        send_op(MODE_RELEASE,  16'h5A5A, 32'h0000_0000, 16'h0000);
        wait_drain();
    endtask

    task automatic test_fill_and_drain();
        int idx;
        refresh_owner_pool();
        for (int k = 0; k <= NSLOTS; k++)
            send_op(MODE_REGISTER, owner_pool[$urandom_range(OWNER_POOL-1)],
                    NUMBER_W'($urandom), REF_W'($urandom));
        // table is full now: hit the last slot and a random one
        send_op(MODE_LOOKUP, tbl_owner[NSLOTS-1], tbl_num[NSLOTS-1], REF_W'($urandom));
        idx = $urandom_range(NSLOTS-1);
        send_op(MODE_LOOKUP, tbl_owner[idx], tbl_num[idx], REF_W'($urandom));
        release_all_live();
        send_op(MODE_REGISTER, owner_pool[1], NUMBER_W'($urandom), REF_W'($urandom));
        wait_drain();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        hold_req++;
        for (int k = 0; k < 24; k++)
            send_op((k % 3 == 0) ? MODE_REGISTER : MODE_LOOKUP, owner_pool[1],
                    NUMBER_W'($urandom_range(3)), REF_W'($urandom));
        wait_drain();
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [MODE_W-1:0]   m;
        logic [OWNER_W-1:0]  own;
        logic [NUMBER_W-1:0] num;
        logic [REF_W-1:0]    rin;
        int                  pick;
        int                  idx;
        bit                  filling;
        release_all_live();
        refresh_owner_pool();
        for (int k = 0; k < n_items; k++)
        begin
            // alternate a filling stretch with a draining one
            filling = (k % 160) < 100;
            pick    = $urandom_range(99);
            own     = owner_pool[$urandom_range(OWNER_POOL-1)];
            num     = ($urandom_range(3) == 0) ? NUMBER_W'($urandom)
                                               : NUMBER_W'($urandom_range(7));
            rin     = REF_W'($urandom);
            if (pick < (filling ? 60 : 30))
                m = MODE_REGISTER;
            else if (pick < (filling ? 93 : 70))
            begin
                m   = MODE_LOOKUP;
                idx = find_live_slot($urandom_range(NSLOTS-1));
                if (idx >= 0 && $urandom_range(9) < 7)
                begin
                    own = tbl_owner[idx];
                    num = tbl_num[idx];
                end
            end
            else if (pick < (filling ? 95 : 92))
                m = MODE_RELEASE;
            else if (pick < 97)
                m = MODE_UNUSED;
            else
            begin
                m   = MODE_W'($urandom);
                own = OWNER_W'($urandom);
                num = NUMBER_W'($urandom);
            end
            send_op(m, own, num, rin);
        end
        wait_drain();
    endtask

    // Response side: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready = 1'b0;
            end
            else
                rsp_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            got.status  = status;
            got.ref_val = endpoint_ref_out;
            got.slot    = slot;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d ref %h slot %0d",
                             got.status, got.ref_val, got.slot);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.ref_val !== want.ref_val ||
                    got.slot !== want.slot)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch at %0t: expected %0d/%h/%0d, got %0d/%h/%0d",
                                 $realtime, want.status, want.ref_val, want.slot,
                                 got.status, got.ref_val, got.slot);
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < NSLOTS; i++)
        begin
            tbl_live[i]  = 1'b0;
            tbl_owner[i] = '0;
            tbl_num[i]   = '0;
            tbl_ref[i]   = '0;
        end
        tbl_hwm = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_fill_and_drain();
        test_backpressure();
        set_idling(0, 0);
        test_random_traffic(RANDOM_ITEMS);
        set_idling(59, 0);
        test_random_traffic(RANDOM_ITEMS);
        set_idling(0, 59);
        test_random_traffic(RANDOM_ITEMS);
        set_idling(13, 13);
        test_random_traffic(RANDOM_ITEMS);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            $display("%0d expected results never arrived", pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule

### files.f
src/ert_pkg.sv
src/ert_mem.sv
src/ert_ctrl.sv
src/endpoint_registry_table.sv
tb/tb.sv
